FILE: hw/rtl/mcw_pkg.sv
// Package for the 3x3 per-channel color median block.
// Holds window sizes, field widths, shared types and the mask bit count.
// No dependencies.
package mcw_pkg;

	localparam int NBR        = 9;                 // neighbors in a 3x3 window
	localparam int CH_W       = 8;                 // bits per color channel
	localparam int NUM_CH     = 3;                 // channels per color
	localparam int COLOR_W    = CH_W * NUM_CH;     // packed color width
	localparam int CNT_W      = 4;                 // holds 0..NBR
	localparam int IN_FIELD_W = NBR * COLOR_W + NBR;
	localparam int IN_DATA_W  = ((IN_FIELD_W + 7) / 8) * 8;
	localparam int OUT_DATA_W = NUM_CH * CH_W;

	typedef logic [CH_W-1:0]    chan_t;
	typedef logic [COLOR_W-1:0] color_t;
	typedef logic [NBR-1:0]     mask_t;
	typedef logic [CNT_W-1:0]   cnt_t;

	// Number of set bits in a neighbor mask.
	function automatic cnt_t mask_count(input mask_t m);
		cnt_t c;
		c = '0;
		for (int k = 0; k < NBR; k++) begin
			c = c + cnt_t'(m[k]);
		end
		return c;
	endfunction

endpackage

FILE: hw/rtl/median3x3_color_window_top.sv
// Top level of the 3x3 per-channel color median block.
// Depends on mcw_pkg and mcw_rank_sel.
//
// Takes one 3x3 color window per transfer and returns one result per window,
// in order. Each of the three 8-bit channels is ranked on its own over the
// neighbors flagged in inside_mask; with N valid neighbors the value of
// ascending rank N/2 is returned (upper middle for even N), so the three
// channels may come from different pixels. An all-zero mask gives zero
// medians and empty_window set. Throughput is one window per clock while
// m_tready is high: the input register feeds three parallel rank selectors
// (72 ordered compares per channel) whose outputs land in the result
// register. The result register decouples the sides, so a new window is
// taken into an empty input register while a result waits for m_tready.
module median3x3_color_window_top
	import mcw_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// s_tdata, from bit 0: color_up_left, color_up, color_up_right, color_left,
	// color_center, color_right, color_down_left, color_down, color_down_right
	// (24 bits each), inside_mask (9 bits), zero fill to 232 bits
	input  logic [IN_DATA_W-1:0]  s_tdata,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// m_tdata, from bit 0: median_ch0, median_ch1, median_ch2 (8 bits each)
	output logic [OUT_DATA_W-1:0] m_tdata,
	// m_tuser: empty_window (1 bit)
	output logic                  m_tuser
);

	// Stage 1: captured window
	logic   vld_s1;
	color_t color_s1 [NBR];
	mask_t  mask_s1;

	// Stage 2: result register
	logic   vld_s2;
	chan_t  med_s2 [NUM_CH];
	logic   empty_s2;

	logic   take_in;
	logic   load_s2;
	cnt_t   valid_cnt;
	cnt_t   target;
	chan_t  ch_vals [NUM_CH][NBR];
	chan_t  ch_med  [NUM_CH];

	// Result register loads when empty or when its result leaves this cycle.
	assign load_s2  = !vld_s2 || m_tready;
	// Input register frees when it is empty or advances into the result.
	assign s_tready = !vld_s1 || load_s2;
	assign take_in  = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (s_tready) begin
				vld_s1 <= s_tvalid;
			end
			if (load_s2) begin
				vld_s2 <= vld_s1;
			end
		end
	end

	// Capture the window payload on each input transfer.
	always_ff @(posedge clk) begin
		if (take_in) begin
			for (int k = 0; k < NBR; k++) begin
				color_s1[k] <= s_tdata[k*COLOR_W +: COLOR_W];
			end
			mask_s1 <= s_tdata[NBR*COLOR_W +: NBR];
		end
	end

	// Target rank is half the number of valid neighbors.
	assign valid_cnt = mask_count(mask_s1);
	assign target    = valid_cnt >> 1;

	// Split each packed color into its channels.
	always_comb begin
		for (int c = 0; c < NUM_CH; c++) begin
			for (int k = 0; k < NBR; k++) begin
				ch_vals[c][k] = color_s1[k][c*CH_W +: CH_W];
			end
		end
	end

	for (genvar c = 0; c < NUM_CH; c++) begin : g_chan
		mcw_rank_sel u_rank_sel (
			.vals   (ch_vals[c]),
			.mask   (mask_s1),
			.target (target),
			.median (ch_med[c])
		);
	end

	// Advance the result; an empty mask already selects zero medians.
	always_ff @(posedge clk) begin
		if (load_s2 && vld_s1) begin
			for (int c = 0; c < NUM_CH; c++) begin
				med_s2[c] <= ch_med[c];
			end
			empty_s2 <= (valid_cnt == '0);
		end
	end

	assign m_tvalid = vld_s2;
	assign m_tdata  = {med_s2[2], med_s2[1], med_s2[0]};
	assign m_tuser  = empty_s2;

endmodule

FILE: hw/rtl/mcw_rank_sel.sv
// Rank selector for one color channel of a 3x3 window.
// Depends on mcw_pkg for widths, types and mask_count.
module mcw_rank_sel
	import mcw_pkg::*;
(
	input  chan_t vals [NBR],
	input  mask_t mask,
	input  cnt_t  target,
	output chan_t median
);

	mask_t below [NBR];
	cnt_t  rank  [NBR];

	// Ties break by neighbor index, so valid ranks are distinct and at most
	// one neighbor hits the target; an empty mask selects nothing.
	always_comb begin
		median = '0;
		for (int i = 0; i < NBR; i++) begin
			for (int j = 0; j < NBR; j++) begin
				below[i][j] = mask[j] && (j != i) &&
					((vals[j] < vals[i]) || ((vals[j] == vals[i]) && (j < i)));
			end
			rank[i] = mask_count(below[i]);
			if (mask[i] && (rank[i] == target)) begin
				median = median | vals[i];
			end
		end
	end

endmodule

FILE: hw/rtl/mcw_checker.sv
// Port-level checker for the 3x3 color median block, bound to its top level.
// Depends on mcw_pkg for port widths.
module mcw_checker
	import mcw_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	input  logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,
	input  logic                  m_tvalid,
	input  logic                  m_tready,
	input  logic [OUT_DATA_W-1:0] m_tdata,
	input  logic                  m_tuser
);

	// Hold a stalled result.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// An empty window carries zero medians.
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata == '0)
		else $error("empty window with nonzero median");

	// A fresh result follows an input transfer, through the input and result registers.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
		else $error("result without matching input transfer");

	// An input transfer with no valid neighbor, entering an idle block, is
	// flagged empty on arrival.
	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(s_tvalid && s_tready) && s_tvalid && s_tready &&
		(s_tdata[NBR*COLOR_W +: NBR] == '0) && !m_tvalid
		##1 1'b1 |=> m_tvalid && m_tuser)
		else $error("empty mask not flagged");

endmodule

bind median3x3_color_window_top mcw_checker u_mcw_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

FILE: bench/tb_median3x3_color_window_top.sv
// Testbench for median3x3_color_window_top: streams 3x3 color windows through
// the block under random source gaps and sink stalls and checks every result.
// Depends on mcw_pkg and the block's RTL; self-checking, no external files.
module tb_median3x3_color_window_top;
	import mcw_pkg::*;

	// Window layout matches s_tdata: colors[0] (up_left) in the lowest bits,
	// inside_mask right above the nine colors, zero fill above that.
	typedef struct packed {
		mask_t            inside_mask;
		color_t [NBR-1:0] colors;
	} window_t;

	// Result layout: m_tdata holds the medians (channel 0 lowest), m_tuser the flag.
	typedef struct packed {
		logic               empty_window;
		chan_t [NUM_CH-1:0] median;
	} medians_t;

	localparam int    RANDOM_PER_PHASE = 290;
	localparam int    DRAIN_CYCLES     = 10;
	localparam mask_t ROW_UP           = 9'b000_000_111;
	localparam mask_t ROW_DOWN         = 9'b111_000_000;
	localparam mask_t COL_LEFT         = 9'b001_001_001;
	localparam mask_t COL_RIGHT        = 9'b100_100_100;

	logic                  clk      = 1'b0;
	logic                  arst_n   = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata  = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  m_tuser;

	window_t  pending_windows[$];   // windows waiting to be offered
	medians_t expected_medians[$];  // predictions for accepted windows, oldest first
	window_t  offered_window;       // window currently held on s_tdata
	int       send_idle_pct  = 0;
	int       recv_stall_pct = 0;
	int       mismatch_count = 0;

	median3x3_color_window_top i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #5 clk = ~clk;

	// Rank each channel over the valid neighbors. Equal values are broken by
	// neighbor index so every valid neighbor has a distinct rank; pick rank N/2.
	function automatic medians_t predict_medians(input window_t w);
		medians_t res;
		int       valid_cnt;
		int       rank;
		chan_t    vi;
		chan_t    vj;
		res       = '0;
		valid_cnt = $countones(w.inside_mask);
		if (valid_cnt == 0) begin
			res.empty_window = 1'b1;
			return res;
		end
		for (int ch = 0; ch < NUM_CH; ch++) begin
			for (int i = 0; i < NBR; i++) begin
				if (w.inside_mask[i]) begin
					vi   = w.colors[i][ch*CH_W +: CH_W];
					rank = 0;
					for (int j = 0; j < NBR; j++) begin
						if (j != i && w.inside_mask[j]) begin
							vj = w.colors[j][ch*CH_W +: CH_W];
							if (vj < vi || (vj == vi && j < i))
								rank++;
						end
					end
					if (rank == valid_cnt / 2)
						res.median[ch] = vi;
				end
			end
		end
		return res;
	endfunction

	// Build a window: mostly interior or image-border masks, sometimes any
	// mask or an empty one; channel values full range, tie-heavy or extreme.
	function automatic window_t random_window();
		window_t w;
		int      style;
		int      pick;
		style = $urandom_range(9);
		for (int k = 0; k < NBR; k++) begin
			for (int ch = 0; ch < NUM_CH; ch++) begin
				case (style)
					6, 7:    w.colors[k][ch*CH_W +: CH_W] = chan_t'($urandom_range(3));
					8:       w.colors[k][ch*CH_W +: CH_W] = $urandom_range(1) ? 8'hFF : 8'h00;
					9:       w.colors[k][ch*CH_W +: CH_W] = chan_t'($urandom_range(130, 126));
					default: w.colors[k][ch*CH_W +: CH_W] = chan_t'($urandom_range(255));
				endcase
			end
		end
		pick = $urandom_range(99);
		if (pick < 55) begin
			w.inside_mask = '1;
		end else if (pick < 80) begin
			// Clear the rows and columns that fall outside a border or corner.
			w.inside_mask = '1;
			if ($urandom_range(3) == 0) w.inside_mask &= ~ROW_UP;
			if ($urandom_range(3) == 0) w.inside_mask &= ~ROW_DOWN;
			if ($urandom_range(3) == 0) w.inside_mask &= ~COL_LEFT;
			if ($urandom_range(3) == 0) w.inside_mask &= ~COL_RIGHT;
		end else if (pick < 97) begin
			w.inside_mask = mask_t'($urandom);
		end else begin
			w.inside_mask = '0;
		end
		return w;
	endfunction

	task automatic report_mismatch(input string what, input int unsigned want,
			input int unsigned got);
		mismatch_count++;
		$display("MISMATCH at %0t: %s expected %0h got %0h", $time, what, want, got);
	endtask

	// Source side: record the prediction when a transfer completes, then
	// offer the next window or idle. Hold the current window while stalled.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
		end else begin
			if (s_tvalid && s_tready)
				expected_medians = {expected_medians, predict_medians(offered_window)};
			if (!s_tvalid || s_tready) begin
				if (pending_windows.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					offered_window = pending_windows.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= IN_DATA_W'(offered_window);
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Sink side: check each completed result against the oldest prediction,
	// then pick the ready level for the next cycle.
	always @(posedge clk or negedge arst_n) begin : result_check
		medians_t want;
		medians_t got;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				got = medians_t'({m_tuser, m_tdata});
				if (expected_medians.size() == 0) begin
					report_mismatch("result with nothing pending", 0, 32'(got));
				end else begin
					want = expected_medians.pop_front();
					for (int ch = 0; ch < NUM_CH; ch++) begin
						if (got.median[ch] !== want.median[ch])
							report_mismatch($sformatf("median_ch%0d", ch),
								32'(want.median[ch]), 32'(got.median[ch]));
					end
					if (got.empty_window !== want.empty_window)
						report_mismatch("empty_window", 32'(want.empty_window),
							32'(got.empty_window));
				end
			end
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Stimulus and end of run.
	initial begin
		window_t dw;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Empty windows: nothing valid, whatever the colors.
		dw = random_window();
		dw.inside_mask = '0;
		pending_windows = {pending_windows, dw};
		dw.colors = '1;
		pending_windows = {pending_windows, dw};
		// Full window at both extremes of the channel range.
		dw.colors = '0;
		dw.inside_mask = '1;
		pending_windows = {pending_windows, dw};
		dw.colors = '1;
		pending_windows = {pending_windows, dw};
		// One valid neighbor at each position: the median is that neighbor.
		for (int k = 0; k < NBR; k++) begin
			dw = random_window();
			dw.inside_mask = mask_t'(1 << k);
			pending_windows = {pending_windows, dw};
		end
		// Channels ordered opposite ways, with the third channel all equal.
		for (int k = 0; k < NBR; k++)
			dw.colors[k] = {8'h80, 8'(8'hF0 - 16 * k), 8'(16 * k + 3)};
		dw.inside_mask = '1;
		pending_windows = {pending_windows, dw};
		// All values equal: ties everywhere.
		for (int k = 0; k < NBR; k++)
			dw.colors[k] = 24'h5A5A5A;
		pending_windows = {pending_windows, dw};
		// Even counts select the upper middle: two, four and eight neighbors.
		dw = random_window();
		dw.inside_mask = 9'h011;
		pending_windows = {pending_windows, dw};
		dw.inside_mask = 9'h0F0;
		pending_windows = {pending_windows, dw};
		dw.inside_mask = 9'h1EF;
		pending_windows = {pending_windows, dw};
		// Alternating black and white, with an odd and an even count.
		for (int k = 0; k < NBR; k++)
			dw.colors[k] = k[0] ? 24'hFFFFFF : 24'h000000;
		dw.inside_mask = '1;
		pending_windows = {pending_windows, dw};
		dw.inside_mask = 9'h0FF;
		pending_windows = {pending_windows, dw};

		// Random windows under each idling pattern in turn.
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 71; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 71; end
				default: begin send_idle_pct = 16; recv_stall_pct = 16; end
			endcase
			for (int n = 0; n < RANDOM_PER_PHASE; n++)
				pending_windows = {pending_windows, random_window()};
			while (pending_windows.size() != 0)
				@(posedge clk);
		end

		// Drain: wait for the last transfer and its result before the final verdict.
		while (pending_windows.size() != 0 || s_tvalid || expected_medians.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	// Watchdog: stop a hung run.
	initial begin
		#2000000;
		$display("Verification failed");
		$finish;
	end

endmodule

FILE: median3x3_color_window_top.f
hw/rtl/mcw_pkg.sv
hw/rtl/mcw_rank_sel.sv
hw/rtl/median3x3_color_window_top.sv
hw/rtl/mcw_checker.sv
bench/tb_median3x3_color_window_top.sv
